// File: design/nctt_pkg.sv
// Shared constants, types and sequencer states for the negative cache TTL table.
// No dependencies; every other design file refers to it by scoped names.
package nctt_pkg;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned SLOT_BITS     = $clog2(SLOTS);
  localparam int unsigned SLOT_OUT_BITS = 6;
  localparam int unsigned STAMP_BITS    = 32;
  localparam int unsigned NOW_BITS      = 32;
  localparam int unsigned KEY_BITS      = 64;
  localparam int unsigned TTL_BITS      = 16;

  localparam logic [TTL_BITS-1:0] TTL_RESET = 16'd300;

  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [TTL_BITS-1:0]   ttl_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);

  // Request from the sequencer to the entry store
  typedef struct packed {
    logic      rd_en;
    slot_idx_t rd_addr;
    logic      wr_en;
    slot_idx_t wr_addr;
    key_t      wr_key;
    stamp_t    wr_stamp;
  } store_req_t;

  // Registered read data from the entry store
  typedef struct packed {
    logic   valid;
    key_t   key;
    stamp_t stamp;
  } store_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_AGE  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_MARK   = 1'b1;

endpackage

// File: design/nctt_req_if.sv
// Request channel: valid/ready handshake carrying one lookup or mark beat.
// Depends on nctt_pkg for field widths.
interface nctt_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  nctt_pkg::key_t       key;
  logic [nctt_pkg::NOW_BITS-1:0] now;

  modport source (output valid, output req_type, output key, output now, input ready);
  modport sink   (input valid, input req_type, input key, input now, output ready);
endinterface

// File: design/nctt_rsp_if.sv
// Response channel: valid/ready handshake carrying one result beat.
// Depends on nctt_pkg for field widths.
interface nctt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                known_bad;
  logic                                was_present;
  logic [nctt_pkg::SLOT_OUT_BITS-1:0]  slot;

  modport source (output valid, output known_bad, output was_present, output slot,
                  input ready);
  modport sink   (input valid, input known_bad, input was_present, input slot,
                  output ready);
endinterface

// File: design/nctt_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the TTL register value.
// Depends on nctt_pkg for the register width.
interface nctt_cfg_if;
  logic           valid;
  logic           ready;
  nctt_pkg::ttl_t ttl_seconds;

  modport source (output valid, output ttl_seconds, input ready);
  modport sink   (input valid, input ttl_seconds, output ready);
endinterface

// File: design/negative_cache_ttl_table_core.sv
// Top level of the negative cache TTL table: TTL register, sequencer and entry store.
// Depends on nctt_pkg, the three channel interfaces, nctt_ctrl and nctt_store.
//
//   channel  role     beat contents
//   req      sink     req_type, key, now
//   rsp      source   known_bad, was_present, slot
//   cfg      sink     ttl_seconds
//
// A request reads the slots in order from slot 0 up to the first matching slot, or all 64 on a
// miss, and a lookup hit then goes through the age subtract before the result beat is loaded.
// The single store read port sets the scan rate.
// Reset clears the valid bits, victim pointer and TTL (to 300) at once; no clearing pass.
// A stalled result waits in the output register; the next request is taken meanwhile.
module negative_cache_ttl_table_core (
  input  logic      clk,
  input  logic      rst,
  nctt_req_if.sink  req,
  nctt_rsp_if.source rsp,
  nctt_cfg_if.sink  cfg
);

  nctt_pkg::ttl_t       ttl;
  nctt_pkg::store_req_t sreq;
  nctt_pkg::store_rsp_t srsp;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= nctt_pkg::TTL_RESET;
    end else if (cfg.valid) begin
      ttl <= cfg.ttl_seconds;
    end
  end

  nctt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .ttl  (ttl),
    .sreq (sreq),
    .srsp (srsp)
  );

  nctt_store u_store (
    .clk  (clk),
    .rst  (rst),
    .sreq (sreq),
    .srsp (srsp)
  );

endmodule

// File: design/nctt_store.sv
// Entry store: key and stamp memories with one write and one registered read port,
// plus per-slot valid flops cleared at reset. Depends on nctt_pkg.
module nctt_store (
  input  logic                 clk,
  input  logic                 rst,
  input  nctt_pkg::store_req_t sreq,
  output nctt_pkg::store_rsp_t srsp
);

  logic [nctt_pkg::SLOTS-1:0] valid_bits;
  nctt_pkg::key_t             key_mem   [nctt_pkg::SLOTS];
  nctt_pkg::stamp_t           stamp_mem [nctt_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (sreq.wr_en) begin
      valid_bits[sreq.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sreq.wr_en) begin
      key_mem[sreq.wr_addr]   <= sreq.wr_key;
      stamp_mem[sreq.wr_addr] <= sreq.wr_stamp;
    end
  end

  // Read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (sreq.rd_en) begin
      srsp.key   <= key_mem[sreq.rd_addr];
      srsp.stamp <= stamp_mem[sreq.rd_addr];
    end
    if (rst) begin
      srsp.valid <= 1'b0;
    end else if (sreq.rd_en) begin
      srsp.valid <= valid_bits[sreq.rd_addr];
    end
  end

endmodule

// File: design/nctt_ctrl.sv
// Sequencer: walks the slots one per cycle through the shared key compare, then ages a lookup
// hit through the shared subtractor and loads the result register. Depends on nctt_pkg.
module nctt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  nctt_req_if.sink             req,
  nctt_rsp_if.source           rsp,
  input  nctt_pkg::ttl_t       ttl,
  output nctt_pkg::store_req_t sreq,
  input  nctt_pkg::store_rsp_t srsp
);

  nctt_pkg::state_t    state;
  logic                req_type_q;
  nctt_pkg::key_t      key_q;
  nctt_pkg::stamp_t    now_q;
  nctt_pkg::slot_idx_t cur;
  nctt_pkg::slot_idx_t slot_q;
  nctt_pkg::slot_idx_t victim;
  logic                present_q;
  nctt_pkg::stamp_t    age_q;

  logic hit;
  logic out_free;
  logic fresh;

  assign hit      = srsp.valid && (srsp.key == key_q);
  assign out_free = !rsp.valid || rsp.ready;
  // Negative age counts as fresh
  assign fresh    = age_q[nctt_pkg::STAMP_BITS-1] ||
                    (age_q < nctt_pkg::stamp_t'(ttl));

  assign req.ready = (state == nctt_pkg::ST_IDLE) && !rst;

  always_comb begin
    sreq.rd_en    = ((state == nctt_pkg::ST_IDLE) && req.valid) ||
                    ((state == nctt_pkg::ST_SCAN) && !hit && (cur != nctt_pkg::LAST_SLOT));
    sreq.rd_addr  = (state == nctt_pkg::ST_IDLE) ? '0 : nctt_pkg::slot_idx_t'(cur + 1'b1);
    sreq.wr_en    = (state == nctt_pkg::ST_DONE) && out_free &&
                    (req_type_q == nctt_pkg::REQ_MARK);
    sreq.wr_addr  = slot_q;
    sreq.wr_key   = key_q;
    sreq.wr_stamp = now_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nctt_pkg::ST_IDLE;
      victim    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one is loaded in the same cycle
      if (rsp.valid && rsp.ready && (state != nctt_pkg::ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        nctt_pkg::ST_IDLE: begin
          if (req.valid) begin
            req_type_q <= req.req_type;
            key_q      <= req.key;
            now_q      <= nctt_pkg::stamp_t'(req.now);
            cur        <= '0;
            state      <= nctt_pkg::ST_SCAN;
          end
        end
        nctt_pkg::ST_SCAN: begin
          if (hit) begin
            slot_q    <= cur;
            present_q <= 1'b1;
            state     <= (req_type_q == nctt_pkg::REQ_MARK) ? nctt_pkg::ST_DONE
                                                           : nctt_pkg::ST_AGE;
          end else if (cur == nctt_pkg::LAST_SLOT) begin
            present_q <= 1'b0;
            slot_q    <= (req_type_q == nctt_pkg::REQ_MARK) ? victim : '0;
            state     <= nctt_pkg::ST_DONE;
          end else begin
            cur <= nctt_pkg::slot_idx_t'(cur + 1'b1);
          end
        end
        nctt_pkg::ST_AGE: begin
          age_q <= now_q - srsp.stamp;
          state <= nctt_pkg::ST_DONE;
        end
        nctt_pkg::ST_DONE: begin
          // Hold until the result register is free
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.known_bad   <= (req_type_q == nctt_pkg::REQ_LOOKUP) && present_q && fresh;
            rsp.was_present <= present_q;
            rsp.slot        <= nctt_pkg::SLOT_OUT_BITS'(slot_q);
            if ((req_type_q == nctt_pkg::REQ_MARK) && !present_q) begin
              victim <= (victim == nctt_pkg::LAST_SLOT) ? '0
                                                        : nctt_pkg::slot_idx_t'(victim + 1'b1);
            end
            state <= nctt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= nctt_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/nctt_chk.sv
// Port-level checker for the negative cache TTL table, bound to the top level.
// Depends on nctt_pkg widths through the port signals only.
module nctt_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               known_bad,
  input logic                               was_present,
  input logic [nctt_pkg::SLOT_OUT_BITS-1:0] slot
);

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(known_bad) &&
                                   $stable(was_present) && $stable(slot)))
    else $error("result beat changed while stalled");

  a_bad_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && known_bad) |-> was_present)
    else $error("known_bad without a present entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a scan is under way");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind negative_cache_ttl_table_core nctt_chk u_nctt_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .known_bad   (rsp.known_bad),
  .was_present (rsp.was_present),
  .slot        (rsp.slot)
);

// File: verif/nctt_cache_checker.sv
`timescale 1ns / 100ps
// Checker for the negative cache TTL table: follows the request, result and TTL channels,
// keeps its own copy of the table and compares each result beat. Depends on nctt_pkg and
// the three channel interfaces.
module nctt_cache_checker (
  input  logic clk,
  input  logic rst,
  nctt_req_if  req,
  nctt_rsp_if  rsp,
  nctt_cfg_if  cfg,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic                               known_bad;
    logic                               was_present;
    logic [nctt_pkg::SLOT_OUT_BITS-1:0] slot;
  } verdict_t;

  logic                held       [nctt_pkg::SLOTS];
  nctt_pkg::key_t      held_key   [nctt_pkg::SLOTS];
  nctt_pkg::stamp_t    held_stamp [nctt_pkg::SLOTS];
  nctt_pkg::slot_idx_t victim;
  nctt_pkg::ttl_t      ttl;
  verdict_t            verdict_q [$];

  // Negative age (sign bit of the wrapped difference) always counts as fresh
  function automatic logic still_fresh(nctt_pkg::stamp_t stamp, nctt_pkg::stamp_t t);
    nctt_pkg::stamp_t age;
    age = t - stamp;
    if (age[nctt_pkg::STAMP_BITS-1]) return 1'b1;
    return age < nctt_pkg::stamp_t'(ttl);
  endfunction

  function automatic verdict_t apply_request(logic rt, nctt_pkg::key_t k,
                                             logic [nctt_pkg::NOW_BITS-1:0] now);
    verdict_t         v;
    int               hit;
    nctt_pkg::stamp_t t;
    v   = '0;
    hit = -1;
    t   = nctt_pkg::stamp_t'(now);
    for (int i = 0; i < nctt_pkg::SLOTS; i++) begin
      if (hit < 0 && held[i] && held_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      v.was_present = 1'b1;
      v.slot        = hit[nctt_pkg::SLOT_OUT_BITS-1:0];
      if (rt == nctt_pkg::REQ_LOOKUP) v.known_bad = still_fresh(held_stamp[hit], t);
      else held_stamp[hit] = t;
    end else if (rt == nctt_pkg::REQ_MARK) begin
      held[victim]       = 1'b1;
      held_key[victim]   = k;
      held_stamp[victim] = t;
      v.slot             = nctt_pkg::SLOT_OUT_BITS'(victim);
      victim             = (victim == nctt_pkg::LAST_SLOT) ? '0 : victim + 1'b1;
    end
    return v;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : follow
    verdict_t want;
    verdict_t got;
    if (rst) begin
      for (int i = 0; i < nctt_pkg::SLOTS; i++) held[i] = 1'b0;
      victim = '0;
      ttl    = nctt_pkg::TTL_RESET;
      verdict_q.delete();
    end else begin
      // retire the result beat first: it always belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        got.known_bad   = rsp.known_bad;
        got.was_present = rsp.was_present;
        got.slot        = rsp.slot;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none, got bad=%0b present=%0b slot=%0d",
                   $time, got.known_bad, got.was_present, got.slot);
        end else begin
          want = verdict_q.pop_front();
          check_field("known_bad", 8'(want.known_bad), 8'(got.known_bad));
          check_field("was_present", 8'(want.was_present), 8'(got.was_present));
          check_field("slot", 8'(want.slot), 8'(got.slot));
        end
      end
      if (cfg.valid && cfg.ready) ttl = cfg.ttl_seconds;
      if (req.valid && req.ready)
        verdict_q.push_back(apply_request(req.req_type, req.key, req.now));
    end
    pending = verdict_q.size();
  end

endmodule

// File: verif/negative_cache_ttl_table_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for negative_cache_ttl_table_core: clock, reset, request and TTL stimulus,
// result back-pressure and the verdict. Depends on nctt_pkg, the channel interfaces and
// nctt_cache_checker, which does all the comparing.
module negative_cache_ttl_table_core_tb;

  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_ITEMS  = 238;
  localparam int KEY_CHOICES  = 80;
  localparam int SETTLE_TAIL  = 100;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;
  int   quiet_cycles = 0;
  int   burst_left = 0;
  nctt_pkg::key_t key_choices [KEY_CHOICES];
  logic [nctt_pkg::NOW_BITS-1:0] clock_now;
  nctt_pkg::ttl_t ttl_now;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  nctt_req_if req_ch ();
  nctt_rsp_if rsp_ch ();
  nctt_cfg_if cfg_ch ();

  negative_cache_ttl_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  nctt_cache_checker cache_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // Result back-pressure: switch between stall patterns after a run of random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:   rsp_ch.ready <= 1'b1;
      RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   rsp_ch.ready <= rx_tick[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the beat until accepted, then carry on the burst or start a new one, dropping valid for any gap drawn
  task automatic send_request(logic rt, nctt_pkg::key_t k, logic [nctt_pkg::NOW_BITS-1:0] t);
    int gap;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.key      <= k;
    req_ch.now      <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_ttl(nctt_pkg::ttl_t value);
    settle();
    @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.ttl_seconds <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ttl_now = value;
  endtask

  task automatic random_phase(int count);
    logic rt;
    nctt_pkg::key_t k;
    logic [nctt_pkg::NOW_BITS-1:0] t;
    int pick;
    for (int n = 0; n < count; n++) begin
      rt   = ($urandom_range(0, 9) < 4) ? nctt_pkg::REQ_MARK : nctt_pkg::REQ_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 88) k = key_choices[$urandom_range(0, KEY_CHOICES - 1)];
      else if (pick < 96) k = {$urandom, $urandom};
      else k = pick[0] ? '1 : '0;
      // advance the wall clock so that revisited keys land on both sides of the TTL
      clock_now += $urandom_range(0, int'(ttl_now) / 32 + 1);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        t = clock_now;
      end else if (pick < 97) begin
        t = clock_now - $urandom_range(0, int'(ttl_now) + 4);
      end else begin
        t = $urandom;
        clock_now = t;
      end
      send_request(rt, k, t);
    end
  endtask

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= nctt_pkg::REQ_LOOKUP;
    req_ch.key         <= '0;
    req_ch.now         <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.ttl_seconds <= nctt_pkg::TTL_RESET;
    rst                <= 1'b1;
    ttl_now   = nctt_pkg::TTL_RESET;
    clock_now = $urandom;
    for (int i = 0; i < KEY_CHOICES; i++) begin
      // every fourth key differs from the first by a single bit
      if (i % 4 == 3) key_choices[i] = key_choices[0] ^ (64'd1 << (i % 64));
      else key_choices[i] = {$urandom, $urandom};
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, TTL at its reset value
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd0);                       // empty table
    send_request(nctt_pkg::REQ_MARK,   '0, 32'd1000);                    // lands in slot 0
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd1299);                    // age just below TTL
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd1300);                    // age equal to TTL
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd999);                     // negative age
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd1000 + 32'h7FFF_FFFF);    // largest positive age
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd1000 + 32'h8000_0000);    // most negative age
    send_request(nctt_pkg::REQ_MARK,   '1, 32'hFFFF_FFFF);               // slot 1
    send_request(nctt_pkg::REQ_LOOKUP, '1, 32'd298);                     // fresh across the wrap
    send_request(nctt_pkg::REQ_LOOKUP, '1, 32'd300);                     // stale across the wrap
    send_request(nctt_pkg::REQ_MARK,   '0, 32'd5000);                    // refresh, pointer holds
    send_request(nctt_pkg::REQ_LOOKUP, '0, 32'd5000);                    // age zero
    send_request(nctt_pkg::REQ_MARK,   64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(nctt_pkg::REQ_MARK,   64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_request(nctt_pkg::REQ_LOOKUP, 64'h5555_5555_5555_5555, 32'h5555_5555 + 32'd299);
    send_request(nctt_pkg::REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA + 32'd300);
    send_request(nctt_pkg::REQ_LOOKUP, 64'd1, 32'd5000);                 // near miss of key zero
    send_request(nctt_pkg::REQ_MARK,   64'd1, 32'd0);                    // slot 4

    write_ttl('0);
    random_phase(PHASE_ITEMS);
    write_ttl('1);
    random_phase(PHASE_ITEMS);
    write_ttl(16'd1);
    random_phase(PHASE_ITEMS);
    write_ttl(nctt_pkg::TTL_RESET);
    random_phase(PHASE_ITEMS);
    write_ttl(nctt_pkg::ttl_t'($urandom_range(2, 2000)));
    random_phase(PHASE_ITEMS);
    write_ttl(nctt_pkg::ttl_t'($urandom));
    random_phase(PHASE_ITEMS);

    settle();
    repeat (SETTLE_TAIL) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
